@@ design/text_window_console_writer_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Shared property forms for the text window console writer.
// ----------------------------------------------------------------------------
`ifndef TEXT_WINDOW_CONSOLE_WRITER_ASSERT_SVH
`define TEXT_WINDOW_CONSOLE_WRITER_ASSERT_SVH

// same-cycle implication
`define TWCW_ASSERT_IMPL(name, clk, rstn, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("twcw assertion failed");

// next-cycle implication
`define TWCW_ASSERT_NEXT(name, clk, rstn, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("twcw assertion failed");

`endif

@@ design/twcw_pkg.sv @@
// ----------------------------------------------------------------------------
// twcw_pkg
// Types and constants of the text window console writer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package twcw_pkg;

  localparam int unsigned DEF_WINDOW_COLUMNS = 32;
  localparam int unsigned DEF_WINDOW_ROWS    = 24;
  localparam int unsigned DEF_GRID_SIDE      = 4;
  localparam int unsigned DEF_TAB_STEP       = 4;

  localparam int unsigned WINDOW_FW = 4;
  localparam int unsigned ROW_FW    = 5;
  localparam int unsigned PEND_FW   = 6;
  localparam int unsigned TILE_FW   = 16;

  localparam logic KIND_WRITE = 1'b0;
  localparam logic KIND_READ  = 1'b1;

  localparam logic [7:0] CH_NEWLINE = 8'd10;
  localparam logic [7:0] CH_TAB     = 8'd9;
  localparam logic [7:0] CH_SPACE   = 8'd32;

  typedef struct packed {
    logic                 kind;
    logic [7:0]           character;
    logic [1:0]           color;
    logic [WINDOW_FW-1:0] window;
    logic [4:0]           read_column;
    logic [4:0]           read_row;
  } in_t;

  typedef struct packed {
    logic [TILE_FW-1:0] tile_value;
    logic [ROW_FW-1:0]  current_row;
    logic [PEND_FW-1:0] pending_count;
  } out_t;

  typedef struct packed {
    logic re;
    logic we;
  } map_ctl_t;

endpackage

`default_nettype wire

@@ design/twcw_map.sv @@
// ----------------------------------------------------------------------------
// twcw_map
// Tile map store: one write port, one registered read port, and a
// clearing sweep after reset.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "text_window_console_writer_assert.svh"

module twcw_map #(
  parameter int unsigned MAP_DEPTH = 12288,
  localparam int unsigned AW = $clog2(MAP_DEPTH)
) (
  input  wire                            clk_i,
  input  wire                            rst_ni,
  input  twcw_pkg::map_ctl_t             ctl_i,
  input  wire [AW-1:0]                   waddr_i,
  input  wire [twcw_pkg::TILE_FW-1:0]    wdata_i,
  input  wire [AW-1:0]                   raddr_i,
  output logic [twcw_pkg::TILE_FW-1:0]   rdata_o,
  output logic                           busy_o
);
  import twcw_pkg::*;

  logic [TILE_FW-1:0] mem [MAP_DEPTH];
  logic               busy_q, busy_d;
  logic [AW-1:0]      clr_q, clr_d;
  logic               we;
  logic [AW-1:0]      wa;
  logic [TILE_FW-1:0] wd;

  always_comb begin
    busy_d = busy_q;
    clr_d  = clr_q;
    if (busy_q) begin
      clr_d = clr_q + 1'b1;
      if (clr_q == AW'(MAP_DEPTH - 1)) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b1;
      clr_q  <= '0;
    end else begin
      busy_q <= busy_d;
      clr_q  <= clr_d;
    end
  end

  assign we = busy_q | ctl_i.we;
  assign wa = busy_q ? clr_q : waddr_i;
  assign wd = busy_q ? '0 : wdata_i;

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[wa] <= wd;
    end
    if (ctl_i.re) begin
      rdata_o <= mem[raddr_i];
    end
  end

  assign busy_o = busy_q;

  `TWCW_ASSERT_IMPL(a_no_write_in_clear, clk_i, rst_ni, busy_q, !ctl_i.we)
  `TWCW_ASSERT_IMPL(a_no_read_in_clear, clk_i, rst_ni, busy_q, !ctl_i.re)
  `TWCW_ASSERT_IMPL(a_clear_complete, clk_i, rst_ni, $fell(busy_q), $past(clr_q) == AW'(MAP_DEPTH - 1))

endmodule

`default_nettype wire

@@ design/twcw_seq.sv @@
// ----------------------------------------------------------------------------
// twcw_seq
// Item sequencer: window state, line buffer store, tile read, fill, scroll and flush.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "text_window_console_writer_assert.svh"

module twcw_seq #(
  parameter int unsigned WINDOW_COLUMNS = 32,
  parameter int unsigned WINDOW_ROWS    = 24,
  parameter int unsigned GRID_SIDE      = 4,
  parameter int unsigned TAB_STEP       = 4,
  localparam int unsigned MC = GRID_SIDE * WINDOW_COLUMNS,
  localparam int unsigned AW = $clog2(MC * GRID_SIDE * WINDOW_ROWS)
) (
  input  wire                           clk_i,
  input  wire                           rst_ni,
  input  wire                           in_valid_i,
  output logic                          in_ready_o,
  input  twcw_pkg::in_t                 in_data_i,
  output logic                          res_valid_o,
  input  wire                           res_ready_i,
  output twcw_pkg::out_t                res_data_o,
  input  wire                           map_busy_i,
  output twcw_pkg::map_ctl_t            map_ctl_o,
  output logic [AW-1:0]                 map_waddr_o,
  output logic [twcw_pkg::TILE_FW-1:0]  map_wdata_o,
  output logic [AW-1:0]                 map_raddr_o,
  input  wire [twcw_pkg::TILE_FW-1:0]   map_rdata_i
);
  import twcw_pkg::*;

  localparam int unsigned WIN_CNT = GRID_SIDE * GRID_SIDE;
  localparam int unsigned WIW     = (WIN_CNT > 1) ? $clog2(WIN_CNT) : 1;
  localparam int unsigned WIN_IDS = 2 ** WINDOW_FW;
  localparam int unsigned LBD     = WIN_CNT * WINDOW_COLUMNS;
  localparam int unsigned LBW     = $clog2(LBD);
  localparam int unsigned PW      = $clog2(WINDOW_COLUMNS + 1);
  localparam int unsigned CW      = $clog2(WINDOW_COLUMNS);
  localparam int unsigned RW      = $clog2(WINDOW_ROWS + 1);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_RD     = 3'd1;
  localparam logic [2:0] S_RDW    = 3'd2;
  localparam logic [2:0] S_FILL   = 3'd3;
  localparam logic [2:0] S_SCROLL = 3'd4;
  localparam logic [2:0] S_FLUSH  = 3'd5;
  localparam logic [2:0] S_RES    = 3'd6;

  localparam logic SRC_MAP  = 1'b0;
  localparam logic SRC_LINE = 1'b1;

  function automatic logic [TILE_FW-1:0] tile_of(input logic [7:0] ch, input logic [1:0] col);
    tile_of = TILE_FW'(ch) - TILE_FW'(CH_SPACE) + {{(TILE_FW-9){1'b0}}, col, 7'b0};
  endfunction

  logic [AW-1:0] win_base [WIN_IDS];
  logic [PW-1:0] tab_end [WINDOW_COLUMNS];

  for (genvar g = 0; g < WIN_IDS; g++) begin : g_base
    assign win_base[g] = AW'(((g / GRID_SIDE) * WINDOW_ROWS * MC) +
                             ((g % GRID_SIDE) * WINDOW_COLUMNS));
  end

  for (genvar g = 0; g < WINDOW_COLUMNS; g++) begin : g_tab
    assign tab_end[g] = PW'(((((g / TAB_STEP) + 1) * TAB_STEP) < WINDOW_COLUMNS) ?
                            (((g / TAB_STEP) + 1) * TAB_STEP) : WINDOW_COLUMNS);
  end

  // window state registers
  logic [RW-1:0] row_q  [WIN_CNT];
  logic [PW-1:0] pend_q [WIN_CNT];
  logic          win_we;
  logic [RW-1:0] win_row_d;
  logic [PW-1:0] win_pend_d;

  // line buffer store
  logic [7:0]     lb_mem [LBD];
  logic [7:0]     lb_rdata_q;
  logic           lb_we, lb_re;
  logic [LBW-1:0] lb_wadr, lb_radr;

  logic [2:0]     st_q, st_d;
  in_t            item_q, item_d;
  logic [WIW-1:0] wi_q, wi_d, wi_in, widx;
  logic [AW-1:0]  base_q, base_d;
  logic [LBW-1:0] lbase_q, lbase_d;
  logic [PW-1:0]  j_q, j_d, j_nx, end_q, end_d;
  logic [7:0]     chr_q, chr_d;
  logic [CW-1:0]  cnt_q, cnt_d;
  logic [RW-1:0]  rcnt_q, rcnt_d;
  logic [AW-1:0]  src_q, src_d, dst_q, dst_d;
  out_t           res_q, res_d;
  logic           wr_q, wr_d;
  logic           wsel_q, wsel_d;
  logic [AW-1:0]  wadr_q, wadr_d;

  logic [RW-1:0]  row_cur, frow;
  logic [PW-1:0]  pend_cur;
  logic           win_ok, in_range;
  logic [AW-1:0]  rd_off;

  assign wi_in    = WIW'(in_data_i.window);
  assign widx     = (st_q == S_IDLE) ? wi_in : wi_q;
  assign row_cur  = row_q[widx];
  assign pend_cur = pend_q[widx];
  assign frow     = (row_cur >= RW'(WINDOW_ROWS)) ? RW'(WINDOW_ROWS - 1) : row_cur;
  assign j_nx     = j_q + 1'b1;

  assign win_ok   = (WIN_CNT >= WIN_IDS) || (in_data_i.window < WINDOW_FW'(WIN_CNT));
  assign in_range = ((WINDOW_COLUMNS >= 32) || (in_data_i.read_column < 5'(WINDOW_COLUMNS))) &&
                    ((WINDOW_ROWS >= 32) || (in_data_i.read_row < 5'(WINDOW_ROWS)));
  assign rd_off   = AW'(32'(item_q.read_row) * MC + 32'(item_q.read_column));

  assign in_ready_o  = (st_q == S_IDLE) && !map_busy_i;
  assign res_valid_o = (st_q == S_RES);
  assign res_data_o  = res_q;

  assign map_waddr_o = wadr_q;
  assign map_wdata_o = (wsel_q == SRC_LINE) ? tile_of(lb_rdata_q, item_q.color) : map_rdata_i;

  always_comb begin
    st_d       = st_q;
    item_d     = item_q;
    wi_d       = wi_q;
    base_d     = base_q;
    lbase_d    = lbase_q;
    j_d        = j_q;
    end_d      = end_q;
    chr_d      = chr_q;
    cnt_d      = cnt_q;
    rcnt_d     = rcnt_q;
    src_d      = src_q;
    dst_d      = dst_q;
    res_d      = res_q;
    wr_d       = 1'b0;
    wsel_d     = wsel_q;
    wadr_d     = wadr_q;
    lb_we      = 1'b0;
    lb_re      = 1'b0;
    lb_wadr    = lbase_q + LBW'(j_q);
    lb_radr    = lbase_q + LBW'(cnt_q);
    map_ctl_o  = '0;
    map_raddr_o = src_q;
    win_we     = 1'b0;
    win_row_d  = row_cur;
    win_pend_d = '0;

    map_ctl_o.we = wr_q;

    unique case (st_q)
      S_IDLE: begin
        if (in_valid_i && in_ready_o) begin
          item_d  = in_data_i;
          wi_d    = wi_in;
          base_d  = win_base[in_data_i.window];
          lbase_d = LBW'(32'(wi_in) * WINDOW_COLUMNS);
          res_d   = '0;
          if (!win_ok) begin
            st_d = S_RES;
          end else if (in_data_i.kind == KIND_READ) begin
            res_d.current_row   = ROW_FW'(row_cur);
            res_d.pending_count = PEND_FW'(pend_cur);
            st_d = in_range ? S_RD : S_RES;
          end else begin
            j_d = pend_cur;
            if (in_data_i.character == CH_NEWLINE) begin
              end_d = PW'(WINDOW_COLUMNS);
              chr_d = CH_SPACE;
            end else if (in_data_i.character == CH_TAB) begin
              end_d = tab_end[pend_cur[CW-1:0]];
              chr_d = CH_SPACE;
            end else begin
              end_d = pend_cur + 1'b1;
              chr_d = in_data_i.character;
            end
            st_d = S_FILL;
          end
        end
      end
      S_RD: begin
        map_ctl_o.re = 1'b1;
        map_raddr_o  = base_q + rd_off;
        st_d         = S_RDW;
      end
      S_RDW: begin
        res_d.tile_value = map_rdata_i;
        st_d             = S_RES;
      end
      S_FILL: begin
        lb_we = 1'b1;
        j_d   = j_nx;
        if (j_nx == end_q) begin
          win_we = 1'b1;
          if (j_nx == PW'(WINDOW_COLUMNS)) begin
            win_row_d           = frow + 1'b1;
            res_d.current_row   = ROW_FW'(frow + 1'b1);
            res_d.pending_count = '0;
            dst_d  = base_q + AW'(32'(frow) * MC);
            src_d  = base_q + AW'(MC);
            cnt_d  = '0;
            rcnt_d = '0;
            st_d   = (row_cur >= RW'(WINDOW_ROWS)) ? S_SCROLL : S_FLUSH;
          end else begin
            win_pend_d          = j_nx;
            res_d.current_row   = ROW_FW'(row_cur);
            res_d.pending_count = PEND_FW'(j_nx);
            st_d                = S_RES;
          end
        end
      end
      S_SCROLL: begin
        map_ctl_o.re = 1'b1;
        map_raddr_o  = src_q;
        wr_d   = 1'b1;
        wsel_d = SRC_MAP;
        wadr_d = src_q - AW'(MC);
        if (cnt_q == CW'(WINDOW_COLUMNS - 1)) begin
          cnt_d  = '0;
          src_d  = src_q + AW'(MC - WINDOW_COLUMNS + 1);
          rcnt_d = rcnt_q + 1'b1;
          if (rcnt_q == RW'(WINDOW_ROWS - 2)) begin
            st_d = S_FLUSH;
          end
        end else begin
          cnt_d = cnt_q + 1'b1;
          src_d = src_q + 1'b1;
        end
      end
      S_FLUSH: begin
        lb_re  = 1'b1;
        wr_d   = 1'b1;
        wsel_d = SRC_LINE;
        wadr_d = dst_q;
        dst_d  = dst_q + 1'b1;
        cnt_d  = cnt_q + 1'b1;
        if (cnt_q == CW'(WINDOW_COLUMNS - 1)) begin
          cnt_d = '0;
          st_d  = S_RES;
        end
      end
      S_RES: begin
        if (res_ready_i) begin
          st_d = S_IDLE;
        end
      end
      default: st_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= S_IDLE;
      wr_q <= 1'b0;
    end else begin
      st_q <= st_d;
      wr_q <= wr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q  <= item_d;
    wi_q    <= wi_d;
    base_q  <= base_d;
    lbase_q <= lbase_d;
    j_q     <= j_d;
    end_q   <= end_d;
    chr_q   <= chr_d;
    cnt_q   <= cnt_d;
    rcnt_q  <= rcnt_d;
    src_q   <= src_d;
    dst_q   <= dst_d;
    res_q   <= res_d;
    wsel_q  <= wsel_d;
    wadr_q  <= wadr_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < WIN_CNT; i++) begin
        row_q[i]  <= '0;
        pend_q[i] <= '0;
      end
    end else if (win_we) begin
      row_q[wi_q]  <= win_row_d;
      pend_q[wi_q] <= win_pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (lb_we) begin
      lb_mem[lb_wadr] <= chr_q;
    end
    if (lb_re) begin
      lb_rdata_q <= lb_mem[lb_radr];
    end
  end

  `TWCW_ASSERT_IMPL(a_fill_bound, clk_i, rst_ni, st_q == S_FILL, j_q < end_q)
  `TWCW_ASSERT_IMPL(a_scroll_apart, clk_i, rst_ni, wr_q && (wsel_q == SRC_MAP), wadr_q != src_q)
  `TWCW_ASSERT_NEXT(a_flush_tail, clk_i, rst_ni, (st_q == S_FLUSH) && (cnt_q == CW'(WINDOW_COLUMNS - 1)), wr_q && (st_q == S_RES))
  `TWCW_ASSERT_IMPL(a_pend_bound, clk_i, rst_ni, win_we, win_pend_d < PW'(WINDOW_COLUMNS))

endmodule

`default_nettype wire

@@ design/text_window_console_writer.sv @@
// ----------------------------------------------------------------------------
// text_window_console_writer
// Text console over a grid of windows in one tile map, with per-window
// line buffers, scroll and tile read-back.
// ----------------------------------------------------------------------------
//  channel | signals                         | word
//  --------+---------------------------------+---------------------------
//  in      | in_valid_i / in_ready_o         | in_data_i  (twcw_pkg::in_t)
//  out     | out_valid_o / out_ready_i       | out_data_o (twcw_pkg::out_t)
//
//  One word at a time. A newline pads the line buffer with spaces to the
//  line end, a tab to the next tab stop. A full line is flushed to the map,
//  and a scroll first moves (WINDOW_ROWS-1)*WINDOW_COLUMNS entries up, one
//  map entry per cycle through the single map write port.
//  After reset the map is cleared, all GRID_SIDE^2*WINDOW_COLUMNS*WINDOW_ROWS
//  entries (12288 by default), with in_ready_o low.
//  A result held in the output register does not stop the next word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module text_window_console_writer #(
  parameter int unsigned WINDOW_COLUMNS = twcw_pkg::DEF_WINDOW_COLUMNS,
  parameter int unsigned WINDOW_ROWS    = twcw_pkg::DEF_WINDOW_ROWS,
  parameter int unsigned GRID_SIDE      = twcw_pkg::DEF_GRID_SIDE,
  parameter int unsigned TAB_STEP       = twcw_pkg::DEF_TAB_STEP
) (
  input  wire             clk_i,
  input  wire             rst_ni,
  input  wire             in_valid_i,
  output logic            in_ready_o,
  input  twcw_pkg::in_t   in_data_i,
  output logic            out_valid_o,
  input  wire             out_ready_i,
  output twcw_pkg::out_t  out_data_o
);
  import twcw_pkg::*;

  localparam int unsigned MAP_DEPTH = GRID_SIDE * WINDOW_COLUMNS * GRID_SIDE * WINDOW_ROWS;
  localparam int unsigned AW        = $clog2(MAP_DEPTH);

  logic               res_valid, res_ready;
  out_t               res_data;
  map_ctl_t           map_ctl;
  logic [AW-1:0]      map_waddr, map_raddr;
  logic [TILE_FW-1:0] map_wdata, map_rdata;
  logic               map_busy;

  out_t out_q;
  logic out_vld_q;

  twcw_seq #(
    .WINDOW_COLUMNS (WINDOW_COLUMNS),
    .WINDOW_ROWS    (WINDOW_ROWS),
    .GRID_SIDE      (GRID_SIDE),
    .TAB_STEP       (TAB_STEP)
  ) u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_data_o  (res_data),
    .map_busy_i  (map_busy),
    .map_ctl_o   (map_ctl),
    .map_waddr_o (map_waddr),
    .map_wdata_o (map_wdata),
    .map_raddr_o (map_raddr),
    .map_rdata_i (map_rdata)
  );

  twcw_map #(
    .MAP_DEPTH (MAP_DEPTH)
  ) u_map (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (map_ctl),
    .waddr_i (map_waddr),
    .wdata_i (map_wdata),
    .raddr_i (map_raddr),
    .rdata_o (map_rdata),
    .busy_o  (map_busy)
  );

  assign res_ready = !out_vld_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_vld_q <= 1'b1;
    end else if (out_ready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      out_q <= res_data;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

@@ bench/text_window_console_writer_test.sv @@
// ----------------------------------------------------------------------------
// text_window_console_writer_test
// Drives character and tile-read words into the console writer with random
// gaps on both channels. Each reply is checked against a local model of the
// tile map, line buffers and window cursors.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module text_window_console_writer_test;
  import twcw_pkg::*;

  localparam int unsigned COLS      = DEF_WINDOW_COLUMNS;
  localparam int unsigned ROWS      = DEF_WINDOW_ROWS;
  localparam int unsigned GRID      = DEF_GRID_SIDE;
  localparam int unsigned TAB       = DEF_TAB_STEP;
  localparam int unsigned MAP_COLS  = GRID * COLS;
  localparam int unsigned MAP_TILES = MAP_COLS * GRID * ROWS;
  localparam int unsigned WIN_COUNT = GRID * GRID;

  logic clk_i     = 1'b0;
  logic rst_ni    = 1'b0;
  logic in_valid  = 1'b0;
  in_t  in_data   = '0;
  logic out_ready = 1'b1;
  logic in_ready;
  logic out_valid;
  out_t out_data;

  text_window_console_writer u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data)
  );

  always #4 clk_i = ~clk_i;

  // console model
  logic [15:0] tile_img [MAP_TILES];
  logic [7:0]  line_img [WIN_COUNT][COLS];
  logic [4:0]  cursor_row [WIN_COUNT];
  logic [5:0]  line_fill [WIN_COUNT];

  out_t due_replies [$];
  int   bad_replies = 0;
  bit   calm = 1'b0;

  function automatic int unsigned idle_draw();
    if (calm || $urandom_range(0, 2) == 0) return 0;
    return $urandom_range(0, 11);
  endfunction

  function automatic out_t console_step(in_t w);
    out_t        r;
    int unsigned base;
    int unsigned j;
    int unsigned row;
    r = '0;
    if (int'(w.window) >= WIN_COUNT) return r;
    base = (w.window / GRID) * ROWS * MAP_COLS + (w.window % GRID) * COLS;
    if (w.kind == KIND_WRITE) begin
      j = 32'(line_fill[w.window]);
      if (w.character == CH_NEWLINE) begin
        while (j < COLS) begin
          line_img[w.window][j] = CH_SPACE;
          j++;
        end
      end else if (w.character == CH_TAB) begin
        do begin
          line_img[w.window][j] = CH_SPACE;
          j++;
        end while (j < COLS && (j % TAB) != 0);
      end else begin
        line_img[w.window][j] = w.character;
        j++;
      end
      line_fill[w.window] = 6'(j);
      if (j >= COLS) begin
        row = 32'(cursor_row[w.window]);
        if (row >= ROWS) begin
          for (int unsigned y = 0; y + 1 < ROWS; y++)
            for (int unsigned x = 0; x < COLS; x++)
              tile_img[base + y * MAP_COLS + x] = tile_img[base + (y + 1) * MAP_COLS + x];
          row = ROWS - 1;
        end
        for (int unsigned x = 0; x < COLS; x++)
          tile_img[base + row * MAP_COLS + x] = 16'(line_img[w.window][x]) - 16'(CH_SPACE)
                                                + 16'(w.color) * 16'd128;
        line_fill[w.window]  = '0;
        cursor_row[w.window] = 5'(row + 1);
      end
    end else if (w.read_column < COLS && w.read_row < ROWS) begin
      r.tile_value = tile_img[base + w.read_row * MAP_COLS + w.read_column];
    end
    r.current_row   = cursor_row[w.window];
    r.pending_count = line_fill[w.window];
    return r;
  endfunction

  // reply check and word capture
  always @(posedge clk_i) begin : reply_check
    out_t due;
    if (rst_ni) begin
      if (out_valid && out_ready) begin
        if (due_replies.size() == 0) begin
          $error("reply with no word outstanding");
          bad_replies++;
        end else begin
          due = due_replies.pop_front();
          if (out_data.tile_value !== due.tile_value) begin
            $error("tile_value: expected %0d, got %0d", due.tile_value, out_data.tile_value);
            bad_replies++;
          end
          if (out_data.current_row !== due.current_row) begin
            $error("current_row: expected %0d, got %0d", due.current_row, out_data.current_row);
            bad_replies++;
          end
          if (out_data.pending_count !== due.pending_count) begin
            $error("pending_count: expected %0d, got %0d", due.pending_count,
                   out_data.pending_count);
            bad_replies++;
          end
        end
      end
      if (in_valid && in_ready) due_replies.push_back(console_step(in_data));
    end
  end

  // reply-side stalls
  always @(posedge clk_i) begin : reply_stall
    int unsigned stall_left;
    if (stall_left != 0) begin
      stall_left--;
      if (stall_left == 0) out_ready <= 1'b1;
    end else if (out_valid && out_ready) begin
      stall_left = idle_draw();
      if (stall_left != 0) out_ready <= 1'b0;
    end
  end

  task automatic send_word(input in_t w);
    int unsigned gap;
    gap = idle_draw();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    do @(posedge clk_i); while (!in_ready);
  endtask

  function automatic in_t char_word(logic [7:0] ch, logic [1:0] color, logic [3:0] win);
    in_t w;
    w = '0;
    w.kind      = KIND_WRITE;
    w.character = ch;
    w.color     = color;
    w.window    = win;
    return w;
  endfunction

  function automatic in_t read_word(logic [3:0] win, logic [4:0] col, logic [4:0] row);
    in_t w;
    w = '0;
    w.kind        = KIND_READ;
    w.window      = win;
    w.read_column = col;
    w.read_row    = row;
    return w;
  endfunction

  task automatic test_cleared_map();
    send_word(read_word(4'd0, 5'd0, 5'd0));
    send_word(read_word(4'd15, 5'd31, 5'd23));
  endtask

  task automatic test_byte_extremes_and_newline();
    send_word(char_word(8'd0, 2'd0, 4'd0));
    send_word(char_word(8'd255, 2'd3, 4'd0));
    send_word(char_word(CH_NEWLINE, 2'd1, 4'd0));
    send_word(read_word(4'd0, 5'd0, 5'd0));
    send_word(read_word(4'd0, 5'd1, 5'd0));
    send_word(read_word(4'd0, 5'd31, 5'd0));
    send_word(read_word(4'd0, 5'd31, 5'd1));
  endtask

  // tabs up to 28, one glyph, then a tab that runs into the line end
  task automatic test_tab_to_line_end();
    repeat (7) send_word(char_word(CH_TAB, 2'd2, 4'd15));
    send_word(char_word(8'h41, 2'd2, 4'd15));
    send_word(char_word(CH_TAB, 2'd2, 4'd15));
    send_word(read_word(4'd15, 5'd28, 5'd0));
    send_word(read_word(4'd15, 5'd29, 5'd0));
  endtask

  task automatic test_out_of_window_reads();
    send_word(read_word(4'd15, 5'd31, 5'd31));
    send_word(read_word(4'd0, 5'd5, 5'd24));
  endtask

  // text mostly into one busy window so that it fills and scrolls
  task automatic test_random_text();
    in_t         w;
    logic [3:0]  busy;
    int unsigned pick;
    for (int i = 0; i < 400; i++) begin
      if (i % 200 == 0) busy = 4'($urandom_range(0, 15));
      calm = ((i / 40) % 4) == 3;
      w = in_t'({$urandom, $urandom});
      pick = $urandom_range(0, 99);
      if (pick < 15) begin
        w.kind = KIND_READ;
        if ($urandom_range(0, 1) == 0) w.window = busy;
        if ($urandom_range(0, 7) != 0) w.read_row = 5'($urandom_range(0, ROWS - 1));
      end else begin
        w.kind = KIND_WRITE;
        if ($urandom_range(0, 9) < 7) w.window = busy;
        pick = $urandom_range(0, 99);
        if (pick < 22) w.character = CH_NEWLINE;
        else if (pick < 32) w.character = CH_TAB;
      end
      send_word(w);
    end
    calm = 1'b0;
  endtask

  initial begin
    foreach (tile_img[k]) tile_img[k] = '0;
    foreach (cursor_row[k]) cursor_row[k] = '0;
    foreach (line_fill[k]) line_fill[k] = '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_cleared_map();
    test_byte_extremes_and_newline();
    test_tab_to_line_end();
    test_out_of_window_reads();
    test_random_text();
    in_valid <= 1'b0;
    do @(posedge clk_i); while (due_replies.size() != 0);
    repeat (40) @(posedge clk_i);
    if (bad_replies == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #16_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
